### hw/rtl/lcc_pkg.sv
package lcc_pkg;

  localparam int ID_W         = 8;
  localparam int POS_W        = 16;
  localparam int LINE_W       = 12;
  localparam int CNT_W        = 32;
  localparam int FRAC_BITS    = 4;
  localparam int MAX_TRACKS_DEF = 256;
  localparam int ID_SPACE     = 2 ** ID_W;

  // compare width for centroid against scaled line coordinate
  localparam int REF_W = LINE_W + FRAC_BITS;
  localparam int CMP_W = (REF_W > POS_W) ? REF_W : POS_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_X0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_Y0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_X1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_Y1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_EN  = 3'd4;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_A    = 2'd1,
    SIDE_B    = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    CROSS_NONE = 2'd0,
    CROSS_AB   = 2'd1,
    CROSS_BA   = 2'd2
  } cross_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_t;

  // classified request passed from front to back
  typedef struct packed {
    logic [ID_W-1:0] track_id;
    side_t           side;
    logic            inactive;
  } lcc_req_t;

  // queue status seen by the back end
  typedef struct packed {
    logic     empty;
    lcc_req_t head;
  } lcc_qstat_t;

endpackage

### hw/rtl/lcc_front.sv
module lcc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lcc_pkg::ID_W-1:0]          in_track_id,
  input  logic [lcc_pkg::POS_W-1:0]         in_pos_x,
  input  logic [lcc_pkg::POS_W-1:0]         in_pos_y,
  input  logic                              in_inactive,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcc_pkg::LINE_W-1:0]        cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output lcc_pkg::lcc_req_t                 q_req
);
  import lcc_pkg::*;

  logic [LINE_W-1:0] line_x0_r, line_y0_r, line_x1_r, line_y1_r;
  logic              line_en_r;
  logic [LINE_W-1:0] dx, dy;
  logic [CMP_W-1:0]  pos_x_ext, pos_y_ext, ref_x, ref_y;
  side_t             side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_x0_r <= '0;
      line_y0_r <= '0;
      line_x1_r <= '0;
      line_y1_r <= '0;
      line_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_X0: line_x0_r <= cfg_data;
        CFG_LINE_Y0: line_y0_r <= cfg_data;
        CFG_LINE_X1: line_x1_r <= cfg_data;
        CFG_LINE_Y1: line_y1_r <= cfg_data;
        CFG_LINE_EN: line_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // orientation from the line spans, then exact compare in fixed point
  always_comb begin
    dx = (line_x0_r >= line_x1_r) ? (line_x0_r - line_x1_r) : (line_x1_r - line_x0_r);
    dy = (line_y0_r >= line_y1_r) ? (line_y0_r - line_y1_r) : (line_y1_r - line_y0_r);
    pos_x_ext = CMP_W'(in_pos_x);
    pos_y_ext = CMP_W'(in_pos_y);
    ref_x     = CMP_W'(line_x0_r) << FRAC_BITS;
    ref_y     = CMP_W'(line_y0_r) << FRAC_BITS;
    side      = SIDE_NONE;
    if (line_en_r) begin
      if (dx < dy) begin
        if (pos_x_ext < ref_x) side = SIDE_A;
        else if (pos_x_ext > ref_x) side = SIDE_B;
      end else if (dx > dy) begin
        if (pos_y_ext > ref_y) side = SIDE_A;
        else if (pos_y_ext < ref_y) side = SIDE_B;
      end
    end
  end

  assign busy            = q_full;
  assign q_push          = start && !busy;
  assign q_req.track_id  = in_track_id;
  assign q_req.side      = side;
  assign q_req.inactive  = in_inactive;

endmodule

### hw/rtl/lcc_queue.sv
module lcc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcc_pkg::lcc_req_t    push_req,
  input  logic                 pop,
  output logic                 full,
  output lcc_pkg::lcc_qstat_t  stat
);
  import lcc_pkg::*;

  lcc_req_t   entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign stat.head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
`endif

endmodule

### hw/rtl/lcc_back.sv
module lcc_back #(
  parameter int MAX_TRACKS = lcc_pkg::MAX_TRACKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcc_pkg::lcc_qstat_t         q_stat,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [1:0]                  out_crossing,
  output logic [1:0]                  out_side_now,
  output logic [lcc_pkg::CNT_W-1:0]   out_total_ab,
  output logic [lcc_pkg::CNT_W-1:0]   out_total_ba
);
  import lcc_pkg::*;

  localparam int TBL_DEPTH = (MAX_TRACKS < ID_SPACE) ? MAX_TRACKS : ID_SPACE;
  localparam int IDX_W     = $clog2(TBL_DEPTH);

  back_state_t         state_r, state_nxt;
  lcc_req_t            item_r;
  logic                old_vld_r;
  side_t               mem_rd_r;
  side_t               side_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  logic [CNT_W-1:0]    cnt_ab_r, cnt_ba_r;
  logic                out_valid_r;
  cross_t              out_cross_r;
  side_t               out_side_r;

  logic [IDX_W-1:0]    rd_idx, wr_idx;
  logic                in_range;
  side_t               old_side;
  cross_t              cross_code;
  logic                wr_set, wr_clr;

  assign rd_idx   = q_stat.head.track_id[IDX_W-1:0];
  assign wr_idx   = item_r.track_id[IDX_W-1:0];
  assign in_range = (32'(item_r.track_id) < MAX_TRACKS);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // table read issued when the request leaves the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r    <= q_stat.head;
      old_vld_r <= vld_r[rd_idx];
      mem_rd_r  <= side_mem[rd_idx];
    end
  end

  always_comb begin
    old_side   = (in_range && old_vld_r) ? mem_rd_r : SIDE_NONE;
    cross_code = CROSS_NONE;
    wr_set     = 1'b0;
    wr_clr     = 1'b0;
    if (in_range) begin
      if (item_r.inactive) begin
        wr_clr = 1'b1;
      end else if (old_side != SIDE_NONE) begin
        if (item_r.side != old_side) begin
          if (old_side == SIDE_A && item_r.side == SIDE_B) cross_code = CROSS_AB;
          else if (old_side == SIDE_B && item_r.side == SIDE_A) cross_code = CROSS_BA;
          wr_clr = 1'b1;
        end
      end else if (item_r.side != SIDE_NONE) begin
        wr_set = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_EXEC && wr_set) side_mem[wr_idx] <= item_r.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cnt_ab_r    <= '0;
      cnt_ba_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == BK_EXEC);
      if (state_r == BK_EXEC) begin
        if (wr_set) vld_r[wr_idx] <= 1'b1;
        if (wr_clr) vld_r[wr_idx] <= 1'b0;
        if (cross_code == CROSS_AB && cnt_ab_r != '1) cnt_ab_r <= cnt_ab_r + 1'b1;
        if (cross_code == CROSS_BA && cnt_ba_r != '1) cnt_ba_r <= cnt_ba_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_EXEC) begin
      out_cross_r <= cross_code;
      out_side_r  <= item_r.side;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_crossing = out_cross_r;
  assign out_side_now = out_side_r;
  assign out_total_ab = cnt_ab_r;
  assign out_total_ba = cnt_ba_r;

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held two cycles");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_EXEC |=> out_valid_r) else $error("executed request gave no result");
  a_ab_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(cnt_ab_r) |-> cnt_ab_r == $past(cnt_ab_r) + 1'b1 && out_valid_r)
    else $error("a to b counter moved by other than one");
  a_ba_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(cnt_ba_r) |-> cnt_ba_r == $past(cnt_ba_r) + 1'b1 && out_valid_r)
    else $error("b to a counter moved by other than one");
`endif

endmodule

### hw/rtl/line_crossing_counter_core.sv
// line crossing counter: counts tracked objects crossing a virtual line
//
// input channel: one track request (in_track_id, in_pos_x, in_pos_y,
//   in_inactive) is taken at a rising edge where start is high and busy low
// result channel: out_valid is high for exactly one cycle per request and
//   carries out_crossing, out_side_now and both crossing totals after it
// config channel: cfg_index selects line_x0, line_y0, line_x1, line_y1 or
//   line_enable; written when cfg_valid and cfg_ready are high (always ready);
//   the user must write only while no request is in flight (not enforced)
// path: queue entry, back end item and table read, result registers
// pacing: the back end completes the side table read-then-write of one
//   request before it pops the next; a 2-entry queue between the classifier
//   and the back end absorbs bursts, and busy rises only when it is full
// reset: synchronous active-low rst_n empties the queue, clears every side
//   table entry through per-entry valid flags at once, zeroes both totals and
//   the line registers; no clearing sweep is needed
// the receiver cannot stall: each result is taken in its strobe cycle
module line_crossing_counter_core #(
  parameter int MAX_TRACKS = lcc_pkg::MAX_TRACKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [lcc_pkg::ID_W-1:0]        in_track_id,
  input  logic [lcc_pkg::POS_W-1:0]       in_pos_x,
  input  logic [lcc_pkg::POS_W-1:0]       in_pos_y,
  input  logic                            in_inactive,
  // result channel
  output logic                            out_valid,
  output logic [1:0]                      out_crossing,
  output logic [1:0]                      out_side_now,
  output logic [lcc_pkg::CNT_W-1:0]       out_total_ab,
  output logic [lcc_pkg::CNT_W-1:0]       out_total_ba,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcc_pkg::LINE_W-1:0]      cfg_data
);
  import lcc_pkg::*;

  logic       q_full, q_push, q_pop;
  lcc_req_t   q_req;
  lcc_qstat_t q_stat;

  // front end: line registers and side classification
  lcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_track_id (in_track_id),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_inactive (in_inactive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (q_req)
  );

  // short request queue decoupling classifier from table update
  lcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .full     (q_full),
    .stat     (q_stat)
  );

  // back end: side table read-modify-write, crossing counters, result
  lcc_back #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_crossing (out_crossing),
    .out_side_now (out_side_now),
    .out_total_ab (out_total_ab),
    .out_total_ba (out_total_ba)
  );

endmodule

### sim/tb_line_crossing_counter_core.sv
`timescale 1ns / 1ps

module tb_line_crossing_counter_core;
  import lcc_pkg::*;

  localparam int TRACKS = MAX_TRACKS_DEF;

  // one track request as it goes onto the input ports
  typedef struct {
    logic [ID_W-1:0]  track_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             inactive;
  } track_req_t;

  // one result as the block should report it
  typedef struct packed {
    cross_t           crossing;
    side_t            side_now;
    logic [CNT_W-1:0] total_ab;
    logic [CNT_W-1:0] total_ba;
  } tally_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ID_W-1:0]      in_track_id = '0;
  logic [POS_W-1:0]     in_pos_x = '0;
  logic [POS_W-1:0]     in_pos_y = '0;
  logic                 in_inactive = 1'b0;
  logic                 out_valid;
  logic [1:0]           out_crossing;
  logic [1:0]           out_side_now;
  logic [CNT_W-1:0]     out_total_ab;
  logic [CNT_W-1:0]     out_total_ba;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LINE_W-1:0]    cfg_data = '0;

  // requests waiting for the driver, and results still owed by the block
  track_req_t track_feed[$];
  tally_t     tallies_due[$];
  track_req_t on_wire;
  tally_t     seen_tally;
  tally_t     want_tally;
  logic       take_next;
  logic       steady = 1'b0;   // no idling on the request side while set
  int         err_count = 0;

  // mirror of the block: line registers, side table and crossing totals
  logic [LINE_W-1:0] lx0, ly0, lx1, ly1;
  logic              l_en;
  side_t             side_mem [TRACKS];
  logic [CNT_W-1:0]  n_ab, n_ba;

  line_crossing_counter_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_track_id  (in_track_id),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_inactive  (in_inactive),
    .out_valid    (out_valid),
    .out_crossing (out_crossing),
    .out_side_now (out_side_now),
    .out_total_ab (out_total_ab),
    .out_total_ba (out_total_ba),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // side of a centroid against the current line, then the table update
  function automatic tally_t tally_track(input track_req_t t);
    tally_t           r;
    side_t            s;
    side_t            old;
    int unsigned      dx;
    int unsigned      dy;
    logic [POS_W-1:0] pivot;
    s  = SIDE_NONE;
    dx = 32'((lx0 > lx1) ? lx0 - lx1 : lx1 - lx0);
    dy = 32'((ly0 > ly1) ? ly0 - ly1 : ly1 - ly0);
    if (l_en) begin
      if (dx < dy) begin
        // mostly vertical line: left of it is A
        pivot = {lx0, {FRAC_BITS{1'b0}}};
        if (t.pos_x < pivot) s = SIDE_A;
        else if (t.pos_x > pivot) s = SIDE_B;
      end else if (dx > dy) begin
        // mostly horizontal line: below it (larger y) is A
        pivot = {ly0, {FRAC_BITS{1'b0}}};
        if (t.pos_y > pivot) s = SIDE_A;
        else if (t.pos_y < pivot) s = SIDE_B;
      end
    end
    r.crossing = CROSS_NONE;
    r.side_now = s;
    if (t.track_id < TRACKS) begin
      old = side_mem[t.track_id];
      if (t.inactive) begin
        side_mem[t.track_id] = SIDE_NONE;
      end else if (old != SIDE_NONE) begin
        // side changed: count a true crossing, forget the track either way
        if (s != old) begin
          if (old == SIDE_A && s == SIDE_B) begin
            r.crossing = CROSS_AB;
            if (n_ab != '1) n_ab = n_ab + 1'b1;
          end else if (old == SIDE_B && s == SIDE_A) begin
            r.crossing = CROSS_BA;
            if (n_ba != '1) n_ba = n_ba + 1'b1;
          end
          side_mem[t.track_id] = SIDE_NONE;
        end
      end else if (s != SIDE_NONE) begin
        side_mem[t.track_id] = s;
      end
    end
    r.total_ab = n_ab;
    r.total_ba = n_ba;
    return r;
  endfunction

  // request driver: holds a request while busy, idles at random otherwise unless steady is set
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        tallies_due.insert(tallies_due.size(), tally_track(on_wire));
        take_next = 1'b1;
      end else begin
        take_next = !start;
      end
      if (take_next) begin
        if (track_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
          on_wire = track_feed.pop_front();
          start       <= 1'b1;
          in_track_id <= on_wire.track_id;
          in_pos_x    <= on_wire.pos_x;
          in_pos_y    <= on_wire.pos_y;
          in_inactive <= on_wire.inactive;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe must match the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_tally = {out_crossing, out_side_now, out_total_ab, out_total_ba};
      if (tallies_due.size() == 0) begin
        $display("%0t: result with nothing owed: crossing %0d side %0d ab %0d ba %0d",
                 $time, out_crossing, out_side_now, out_total_ab, out_total_ba);
        err_count++;
      end else begin
        want_tally = tallies_due.pop_front();
        if (seen_tally !== want_tally) begin
          $display("%0t: mismatch crossing exp %0d got %0d, side exp %0d got %0d,",
                   $time, want_tally.crossing, out_crossing, want_tally.side_now,
                   out_side_now, " ab exp %0d got %0d, ba exp %0d got %0d",
                   want_tally.total_ab, out_total_ab,
                   want_tally.total_ba, out_total_ba);
          err_count++;
        end
      end
    end
  end

  task automatic push_item(input logic [ID_W-1:0] id, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic inact);
    track_req_t t;
    t.track_id = id;
    t.pos_x    = x;
    t.pos_y    = y;
    t.inactive = inact;
    track_feed.insert(track_feed.size(), t);
  endtask

  // config write; the mirror follows only when the handshake completes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LINE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LINE_X0: lx0 = val;
      CFG_LINE_Y0: ly0 = val;
      CFG_LINE_X1: lx1 = val;
      CFG_LINE_Y1: ly1 = val;
      CFG_LINE_EN: l_en = val[0];
      default: ;
    endcase
  endtask

  task automatic set_line(input logic [LINE_W-1:0] x0, input logic [LINE_W-1:0] y0,
                          input logic [LINE_W-1:0] x1, input logic [LINE_W-1:0] y1,
                          input logic [LINE_W-1:0] en_word);
    write_reg(CFG_LINE_X0, x0);
    write_reg(CFG_LINE_Y0, y0);
    write_reg(CFG_LINE_X1, x1);
    write_reg(CFG_LINE_Y1, y1);
    write_reg(CFG_LINE_EN, en_word);
  endtask

  // wait until every request is in and every result is out, then drain
  task automatic settle();
    do @(negedge clk);
    while (track_feed.size() != 0 || start || tallies_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [LINE_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return LINE_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return POS_W'($urandom);
  endfunction

  // a point below / above the pivot, mostly close to it; the pivot itself if there is no room
  function automatic logic [POS_W-1:0] pos_below(input logic [POS_W-1:0] pivot);
    int unsigned lim;
    if (pivot == 0) return pivot;
    lim = ($urandom_range(0, 3) == 0 || pivot < 64) ? pivot : 64;
    return pivot - POS_W'($urandom_range(1, lim));
  endfunction

  function automatic logic [POS_W-1:0] pos_above(input logic [POS_W-1:0] pivot);
    int unsigned lim;
    int unsigned room;
    room = 65535 - pivot;
    if (room == 0) return pivot;
    lim = ($urandom_range(0, 3) == 0 || room < 64) ? room : 64;
    return pivot + POS_W'($urandom_range(1, lim));
  endfunction

  // random line setting, then a run of tracks that mostly hop across it
  task automatic random_phase(input int n_items);
    int unsigned       kind;
    int unsigned       dx;
    int unsigned       dy;
    int unsigned       d;
    int unsigned       pick;
    logic [LINE_W-1:0] a, b, c, e;
    logic [ID_W-1:0]   pool [12];
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  px, py;
    logic [POS_W-1:0]  pivot;
    logic              vert, horiz;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      // vertical for 0..3, horizontal for 4..7
      do begin
        a  = pick_coord();
        b  = pick_coord();
        c  = pick_coord();
        e  = pick_coord();
        dx = 32'((a > c) ? a - c : c - a);
        dy = 32'((b > e) ? b - e : e - b);
      end while ((kind < 4) ? !(dx < dy) : !(dx > dy));
    end else begin
      // equal spans, or any line that gets disabled
      a = pick_coord();
      b = pick_coord();
      d = $urandom_range(0, 4095 - ((a > b) ? a : b));
      c = a + LINE_W'(d);
      e = b + LINE_W'(d);
    end
    set_line(a, b, c, e,
             {(LINE_W-1)'($urandom_range(0, 2047)), 1'b0} | LINE_W'(kind != 9));
    write_reg(CFG_LINE_EN + CFG_IDX_W'($urandom_range(1, 3)), LINE_W'($urandom));
    vert  = l_en && (dx < dy) && kind < 8;
    horiz = l_en && (dx > dy) && kind < 8;
    for (int k = 0; k < 12; k++) pool[k] = ID_W'($urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      id   = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 255))
                                         : pool[$urandom_range(0, 11)];
      px   = pick_pos();
      py   = pick_pos();
      pick = $urandom_range(0, 99);
      if (vert) begin
        pivot = {lx0, {FRAC_BITS{1'b0}}};
        if (pick < 42) px = pos_below(pivot);
        else if (pick < 84) px = pos_above(pivot);
        else if (pick < 92) px = pivot;
      end else if (horiz) begin
        pivot = {ly0, {FRAC_BITS{1'b0}}};
        if (pick < 42) py = pos_above(pivot);
        else if (pick < 84) py = pos_below(pivot);
        else if (pick < 92) py = pivot;
      end
      push_item(id, px, py, $urandom_range(0, 99) < 8);
    end
  endtask

  initial begin
    lx0  = '0;
    ly0  = '0;
    lx1  = '0;
    ly1  = '0;
    l_en = 1'b0;
    n_ab = '0;
    n_ba = '0;
    foreach (side_mem[k]) side_mem[k] = SIDE_NONE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: line disabled, nothing has a side
    push_item(8'd0, 16'h0000, 16'h0000, 1'b0);
    push_item(8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    settle();

    // vertical line at x = 100 px, pivot 1600 in fixed point
    set_line(12'd100, 12'd0, 12'd100, 12'd4095, 12'h001);
    push_item(8'd1, 16'd1599, 16'h1234, 1'b0);    // store A
    push_item(8'd1, 16'd1601, 16'h4321, 1'b0);    // A to B
    push_item(8'd2, 16'hFFFF, 16'h0000, 1'b0);    // store B
    push_item(8'd2, 16'h0000, 16'hFFFF, 1'b0);    // B to A
    push_item(8'd3, 16'd100, 16'd7, 1'b0);        // store A
    push_item(8'd3, 16'd1600, 16'd7, 1'b0);       // onto the line: cleared, no count
    push_item(8'd3, 16'd2000, 16'd7, 1'b0);       // fresh B
    push_item(8'd4, 16'd10, 16'd9, 1'b0);         // store A
    push_item(8'd4, 16'd20, 16'd9, 1'b0);         // same side, no change
    push_item(8'd4, 16'd30, 16'd9, 1'b1);         // inactive clears
    push_item(8'd4, 16'd5000, 16'd9, 1'b0);       // fresh B, no crossing
    push_item(8'd5, 16'd1600, 16'd9, 1'b0);       // new on the line: not stored
    push_item(8'd5, 16'd3000, 16'd9, 1'b0);       // store B
    push_item(8'd255, 16'd1000, 16'h8000, 1'b0);  // store A at top id
    settle();

    // mostly horizontal line at the top of the y range, pivot 65520
    set_line(12'd0, 12'd4095, 12'd4095, 12'd10, 12'h001);
    push_item(8'd255, 16'h5555, 16'hFFFF, 1'b0);  // A again, entry kept
    push_item(8'd255, 16'hAAAA, 16'h0000, 1'b0);  // A to B
    push_item(8'd5, 16'h0000, 16'd65520, 1'b0);   // on the line clears B
    push_item(8'd6, 16'hFFFF, 16'd65521, 1'b0);   // store A just above
    push_item(8'd6, 16'hFFFF, 16'd65519, 1'b0);   // A to B
    settle();

    // equal spans: no side at all, stored entries get cleared
    set_line(12'd0, 12'd0, 12'd4095, 12'd4095, 12'h001);
    push_item(8'd3, 16'd0, 16'd0, 1'b0);
    push_item(8'd4, 16'hFFFF, 16'hFFFF, 1'b0);
    settle();

    // vertical geometry, enable word with only upper bits set, stray index
    set_line(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'hFFE);
    write_reg(CFG_LINE_EN + CFG_IDX_W'(3), 12'hFFF);
    push_item(8'd7, 16'd0, 16'd0, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      steady = (p == 2);
      random_phase(160);
      settle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_front.sv
hw/rtl/lcc_queue.sv
hw/rtl/lcc_back.sv
hw/rtl/line_crossing_counter_core.sv
sim/tb_line_crossing_counter_core.sv
